### hdl/dcct_pkg.sv
// Shared types and constants for the dot conflict-count table.
// Used by dcct_dot and dot_conflict_count_table; no dependencies.
package dcct_pkg;

  localparam int VEC_DIM = 13;
  localparam int COORD_W = 8;
  localparam int VEC_W   = VEC_DIM * COORD_W;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SUM_W   = 19;
  localparam int GRP_SZ  = 4;
  localparam int GRP_N   = (VEC_DIM + GRP_SZ - 1) / GRP_SZ;
  localparam int DOT_LAT = 3;

  localparam int THR_W   = 19;
  localparam int PSZ_W   = 13;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int TOT_W   = 13;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 3;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = 13'd4096;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ACTIVE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_INACTIVE = 3'd3;
  localparam logic [STAT_W-1:0] ST_LOAD_REF = 3'd4;

  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_POOL   = 1'b1;

  typedef struct packed {
    logic             act;
    logic [CNT_W-1:0] cnt;
  } dcct_ent_t;

endpackage

### hdl/dcct_dot.sv
// Pipelined 13-term signed-byte dot product, three register stages.
// Depends on dcct_pkg.
module dcct_dot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [dcct_pkg::VEC_W-1:0]        vec_a,
  input  logic [dcct_pkg::VEC_W-1:0]        vec_b,
  output logic                              out_valid,
  output logic signed [dcct_pkg::SUM_W-1:0] out_sum,
  output logic                              busy
);
  import dcct_pkg::*;

  logic signed [PROD_W-1:0] prod     [VEC_DIM];
  logic signed [PROD_W-1:0] prod_r   [VEC_DIM];
  logic signed [SUM_W-1:0]  part     [GRP_N];
  logic signed [SUM_W-1:0]  part_r   [GRP_N];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     v1_r, v2_r, v3_r;

  always_comb begin
    logic signed [COORD_W-1:0] ca;
    logic signed [COORD_W-1:0] cb;
    for (int c = 0; c < VEC_DIM; c++) begin
      ca      = vec_a[c*COORD_W +: COORD_W];
      cb      = vec_b[c*COORD_W +: COORD_W];
      prod[c] = ca * cb;
    end
  end

  // partial sums in groups of four, then the final add
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      part[g] = '0;
      for (int j = 0; j < GRP_SZ; j++) begin
        if (g * GRP_SZ + j < VEC_DIM) begin
          part[g] = part[g] + SUM_W'(prod_r[g * GRP_SZ + j]);
        end
      end
    end
    sum = '0;
    for (int g = 0; g < GRP_N; g++) begin
      sum = sum + part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    part_r <= part;
    sum_r  <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_sum   = sum_r;
  assign busy      = v1_r | v2_r | v3_r;

endmodule

### hdl/dot_conflict_count_table.sv
// Conflict-count table: pool of signed-byte vectors, active set and blocker counts.
// Input stream carries load/add/remove/query items; one result per item on the output.
// Threshold and pool size are set through an APB-style port.
// After reset the entry state memory is cleared, one entry per cycle, across all
// POOL_DEPTH entries; in_tready stays low until that pass ends (register writes still work).
// Items are handled one at a time. Load and query go from evaluation straight to the
// done state. Add and remove read and write the named entry, then walk entries
// 0 .. min(pool_size, POOL_DEPTH)-1 through the state and vector memories, one entry
// per cycle into a three-stage dot-product pipeline and a write-back; the single read
// port of each memory sets this rate.
// Refused items (bad index, double add, remove of inactive, load with a non-empty
// set) take the short path and change nothing.
// Results sit in an output register; the next item is taken while it waits. If the
// receiver stalls, a finished item waits in the done state until the register frees.
// Depends on dcct_pkg and dcct_dot.
module dot_conflict_count_table #(
  parameter int POOL_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index [11:0], vec_low [75:12], vec_high [115:76], zero pad
  input  logic [dcct_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type [1:0]
  input  logic [dcct_pkg::REQ_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // is_active [0], blockers [13:1], active_total [26:14], zero pad
  output logic [dcct_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status [2:0]
  output logic [dcct_pkg::STAT_W-1:0]      out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dcct_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [dcct_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [dcct_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import dcct_pkg::*;

  localparam int AW    = $clog2(POOL_DEPTH);
  localparam int LIM_W = $clog2(POOL_DEPTH + 1);
  localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(POOL_DEPTH);
  localparam logic [AW-1:0]    LAST_ENT = AW'(POOL_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state_r;
  logic signed [THR_W-1:0] thr_r;
  logic [PSZ_W-1:0]        psz_r;
  logic [TOT_W-1:0]        set_size_r;
  logic [AW-1:0]           clr_r;
  logic [LIM_W-1:0]        wk_r;
  logic                    iss_done_r;
  logic [LIM_W-1:0]        lim;

  // item held for the whole operation
  logic [REQ_W-1:0]        req_r;
  logic [IDX_W-1:0]        k_r;
  logic [VEC_W-1:0]        vin_r;
  logic [VEC_W-1:0]        vk_r;
  logic [AW-1:0]           kaddr;
  logic                    bad_idx;
  logic                    raise;

  // memories
  logic [VEC_W-1:0]        vec_mem [POOL_DEPTH];
  dcct_ent_t               st_mem  [POOL_DEPTH];
  logic [VEC_W-1:0]        vec_rd_r;
  dcct_ent_t               st_rd_r;
  logic [AW-1:0]           rd_addr;
  logic                    vec_we;
  logic                    st_we;
  logic [AW-1:0]           st_wa;
  dcct_ent_t               st_wd;

  // evaluation of the named entry
  logic [STAT_W-1:0]       ev_status;
  logic                    ev_walk;
  logic                    ev_load;

  // result holding and output registers
  logic [STAT_W-1:0]       res_status_r;
  logic                    res_act_r;
  logic [CNT_W-1:0]        res_cnt_r;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic                    out_act_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic [TOT_W-1:0]        out_tot_r;

  // walk pipeline
  logic                    issue;
  logic                    v1_r;
  logic [AW-1:0]           idx1_r;
  logic                    skip1;
  logic                    tg_skip_r [DOT_LAT];
  logic [AW-1:0]           tg_idx_r  [DOT_LAT];
  logic [CNT_W-1:0]        tg_cnt_r  [DOT_LAT];
  logic                    dot_valid;
  logic signed [SUM_W-1:0] dot_sum;
  logic                    dot_busy;
  logic                    wb_hit;
  logic [CNT_W-1:0]        wb_cnt;
  logic [CNT_W-1:0]        new_cnt;
  logic                    walk_end;
  logic                    cfg_wr;
  logic                    out_free;

  // ---- configuration ----
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(8);
      psz_r <= PSZ_W'(4096);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_THRESH) begin
        thr_r <= cfg_pwdata[THR_W-1:0];
      end else begin
        psz_r <= cfg_pwdata[PSZ_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_POOL) begin
      cfg_prdata = {{(CFG_DW-PSZ_W){1'b0}}, psz_r};
    end else begin
      cfg_prdata = {{(CFG_DW-THR_W){thr_r[THR_W-1]}}, thr_r};
    end
  end

  assign lim     = (32'(psz_r) > 32'(POOL_DEPTH)) ? LIM_MAX : LIM_W'(psz_r);
  assign kaddr   = AW'(k_r);
  assign bad_idx = 32'(k_r) >= 32'(lim);
  assign raise   = (req_r == REQ_ADD);

  // ---- input transfer ----
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= in_tuser;
      k_r   <= in_tdata[IDX_W-1:0];
      vin_r <= in_tdata[IDX_W +: VEC_W];
    end
  end

  // ---- memories ----
  assign rd_addr = (state_r == S_IDLE) ? AW'(in_tdata[IDX_W-1:0]) : wk_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[kaddr] <= vin_r;
    end
    vec_rd_r <= vec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    st_rd_r <= st_mem[rd_addr];
  end

  // ---- evaluation of the named entry ----
  always_comb begin
    ev_status = ST_OK;
    ev_walk   = 1'b0;
    ev_load   = 1'b0;
    if (bad_idx) begin
      ev_status = ST_RANGE;
    end else begin
      unique case (req_r)
        REQ_LOAD: begin
          if (set_size_r != '0) ev_status = ST_LOAD_REF;
          else ev_load = 1'b1;
        end
        REQ_ADD: begin
          if (st_rd_r.act) ev_status = ST_ACTIVE;
          else ev_walk = 1'b1;
        end
        REQ_REMOVE: begin
          if (!st_rd_r.act) ev_status = ST_INACTIVE;
          else ev_walk = 1'b1;
        end
        REQ_QUERY: begin
          ev_status = ST_OK;
        end
      endcase
    end
  end

  assign vec_we = (state_r == S_EVAL) && ev_load;

  // state memory write port: clearing pass, named entry, walk write-back
  always_comb begin
    st_we = 1'b0;
    st_wa = kaddr;
    st_wd = '0;
    priority if (state_r == S_CLEAR) begin
      st_we = 1'b1;
      st_wa = clr_r;
    end else if (state_r == S_EVAL && ev_walk) begin
      st_we     = 1'b1;
      st_wd.act = raise;
      st_wd.cnt = st_rd_r.cnt;
    end else if (wb_hit) begin
      st_we     = 1'b1;
      st_wa     = tg_idx_r[DOT_LAT-1];
      st_wd.cnt = new_cnt;
    end
  end

  // ---- walk pipeline ----
  assign issue = (state_r == S_WALK) && !iss_done_r;
  assign skip1 = (idx1_r == kaddr) || st_rd_r.act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r      <= wk_r[AW-1:0];
    tg_skip_r[0] <= skip1;
    tg_idx_r[0]  <= idx1_r;
    tg_cnt_r[0]  <= st_rd_r.cnt;
    for (int s = 1; s < DOT_LAT; s++) begin
      tg_skip_r[s] <= tg_skip_r[s-1];
      tg_idx_r[s]  <= tg_idx_r[s-1];
      tg_cnt_r[s]  <= tg_cnt_r[s-1];
    end
  end

  dcct_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .vec_a     (vk_r),
    .vec_b     (vec_rd_r),
    .out_valid (dot_valid),
    .out_sum   (dot_sum),
    .busy      (dot_busy)
  );

  assign wb_cnt = tg_cnt_r[DOT_LAT-1];
  assign wb_hit = dot_valid && !tg_skip_r[DOT_LAT-1] && (dot_sum > thr_r);

  always_comb begin
    new_cnt = wb_cnt;
    if (raise) begin
      if (wb_cnt < CNT_MAX) new_cnt = wb_cnt + 1'b1;
    end else begin
      if (wb_cnt != '0) new_cnt = wb_cnt - 1'b1;
    end
  end

  assign walk_end = iss_done_r && !v1_r && !dot_busy;
  assign out_free = !out_valid_r || out_tready;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      wk_r       <= '0;
      iss_done_r <= 1'b0;
      set_size_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_ENT) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          wk_r       <= '0;
          iss_done_r <= 1'b0;
          if (ev_walk) begin
            state_r <= S_WALK;
            if (raise) begin
              set_size_r <= set_size_r + 1'b1;
            end else if (set_size_r != '0) begin
              set_size_r <= set_size_r - 1'b1;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_WALK: begin
          if (issue) begin
            wk_r <= wk_r + 1'b1;
            if (wk_r + 1'b1 == lim) iss_done_r <= 1'b1;
          end
          if (walk_end) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      vk_r         <= vec_rd_r;
      res_status_r <= ev_status;
      if (bad_idx) begin
        res_act_r <= 1'b0;
        res_cnt_r <= '0;
      end else begin
        res_act_r <= ev_walk ? raise : st_rd_r.act;
        res_cnt_r <= st_rd_r.cnt;
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_act_r    <= res_act_r;
      out_cnt_r    <= res_cnt_r;
      out_tot_r    <= set_size_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W-1-CNT_W-TOT_W){1'b0}}, out_tot_r, out_cnt_r, out_act_r};

  // ---- checks ----
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EVAL))
    else $error("accepted item not evaluated next cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !st_we)
    else $error("state memory written outside clear, evaluate or walk");

  a_wb_not_named: assert property (@(posedge clk) disable iff (!rst_n)
    wb_hit |-> (tg_idx_r[DOT_LAT-1] != kaddr))
    else $error("walk write-back hit the named entry");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (wk_r <= lim))
    else $error("walk counter ran past the pool limit");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && ev_walk && raise) |=> (set_size_r == $past(set_size_r) + 1'b1))
    else $error("set size not raised on add");

endmodule
